// ===== rtl/fcf_pkg.sv =====
// ---------------------------------------------------------------------------
// fcf_pkg
// Types and constants for the fingerprint module command packet framer.
// ---------------------------------------------------------------------------
package fcf_pkg;

    typedef struct packed {
        logic [3:0]  opcode;
        logic [1:0]  buffer_id;
        logic [15:0] page_id;
        logic [15:0] page_count;
    } cmd_t;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       last_byte;
    } pkt_t;

    // command codes
    localparam logic [3:0] OP_HANDSHAKE = 4'd0;
    localparam logic [3:0] OP_GENIMG    = 4'd1;
    localparam logic [3:0] OP_IMG2TZ    = 4'd2;
    localparam logic [3:0] OP_REGMODEL  = 4'd3;
    localparam logic [3:0] OP_STORE     = 4'd4;
    localparam logic [3:0] OP_SEARCH    = 4'd5;
    localparam logic [3:0] OP_EMPTY     = 4'd6;
    localparam logic [3:0] OP_DELETE    = 4'd7;
    localparam logic [3:0] OP_LOAD      = 4'd8;
    localparam logic [3:0] OP_MATCH     = 4'd9;

    // instruction bytes on the wire
    localparam logic [7:0] INS_HANDSHAKE = 8'h40;
    localparam logic [7:0] INS_GENIMG    = 8'h01;
    localparam logic [7:0] INS_IMG2TZ    = 8'h02;
    localparam logic [7:0] INS_REGMODEL  = 8'h05;
    localparam logic [7:0] INS_STORE     = 8'h06;
    localparam logic [7:0] INS_SEARCH    = 8'h04;
    localparam logic [7:0] INS_EMPTY     = 8'h0D;
    localparam logic [7:0] INS_DELETE    = 8'h0C;
    localparam logic [7:0] INS_LOAD      = 8'h07;
    localparam logic [7:0] INS_MATCH     = 8'h03;

    localparam logic [7:0] HEADER_HI   = 8'hEF;
    localparam logic [7:0] HEADER_LO   = 8'h01;
    localparam logic [7:0] PID_COMMAND = 8'h01;

    localparam logic [31:0] MODULE_ADDRESS_RESET = 32'hFFFF_FFFF;
    localparam logic        REG_MODULE_ADDRESS   = 1'b0;

    localparam int          MAX_PARAMS = 5;
    localparam logic [4:0]  PARAM_BASE = 5'd10;

endpackage

// ===== rtl/fcf_encode.sv =====
// ---------------------------------------------------------------------------
// fcf_encode
// Selects one packet byte of a registered command by byte position,
// including instruction, parameter list and checksum.
// ---------------------------------------------------------------------------
module fcf_encode
(
    input  fcf_pkg::cmd_t cmd,
    input  logic [31:0]   module_address,
    input  logic [4:0]    idx,
    output fcf_pkg::pkt_t pkt
);

    logic [7:0]       instr;
    logic [2:0]       np;
    logic [4:0][7:0]  par;
    logic [7:0]       len;
    logic [15:0]      sum;
    logic [4:0]       off;
    logic [7:0]       buf_byte;

    assign buf_byte = {6'd0, cmd.buffer_id};

    always_comb
    begin
        instr = 8'h00;
        np    = 3'd0;
        par   = '0;
        unique case (cmd.opcode)
            fcf_pkg::OP_HANDSHAKE: instr = fcf_pkg::INS_HANDSHAKE;
            fcf_pkg::OP_GENIMG:    instr = fcf_pkg::INS_GENIMG;
            fcf_pkg::OP_IMG2TZ:
            begin
                instr  = fcf_pkg::INS_IMG2TZ;
                par[0] = buf_byte;
                np     = 3'd1;
            end
            fcf_pkg::OP_REGMODEL:  instr = fcf_pkg::INS_REGMODEL;
            fcf_pkg::OP_STORE:
            begin
                instr  = fcf_pkg::INS_STORE;
                par[0] = buf_byte;
                par[1] = cmd.page_id[15:8];
                par[2] = cmd.page_id[7:0];
                np     = 3'd3;
            end
            fcf_pkg::OP_SEARCH:
            begin
                instr  = fcf_pkg::INS_SEARCH;
                par[0] = buf_byte;
                par[1] = cmd.page_id[15:8];
                par[2] = cmd.page_id[7:0];
                par[3] = cmd.page_count[15:8];
                par[4] = cmd.page_count[7:0];
                np     = 3'd5;
            end
            fcf_pkg::OP_EMPTY:     instr = fcf_pkg::INS_EMPTY;
            fcf_pkg::OP_DELETE:
            begin
                instr  = fcf_pkg::INS_DELETE;
                par[0] = cmd.page_id[15:8];
                par[1] = cmd.page_id[7:0];
                par[2] = 8'h00;
                par[3] = 8'h01;
                np     = 3'd4;
            end
            fcf_pkg::OP_LOAD:
            begin
                instr  = fcf_pkg::INS_LOAD;
                par[0] = buf_byte;
                par[1] = cmd.page_id[15:8];
                par[2] = cmd.page_id[7:0];
                np     = 3'd3;
            end
            fcf_pkg::OP_MATCH:     instr = fcf_pkg::INS_MATCH;
            default:               instr = 8'h00;
        endcase
    end

    assign len = {5'd0, np} + 8'd3;
    assign sum = 16'(fcf_pkg::PID_COMMAND) + 16'(len) + 16'(instr)
               + 16'(par[0]) + 16'(par[1]) + 16'(par[2])
               + 16'(par[3]) + 16'(par[4]);
    assign off = idx - fcf_pkg::PARAM_BASE;

    always_comb
    begin
        pkt.last_byte = 1'b0;
        pkt.tx_byte   = 8'h00;
        if (idx < fcf_pkg::PARAM_BASE)
        begin
            case (idx)
                5'd0:    pkt.tx_byte = fcf_pkg::HEADER_HI;
                5'd1:    pkt.tx_byte = fcf_pkg::HEADER_LO;
                5'd2:    pkt.tx_byte = module_address[31:24];
                5'd3:    pkt.tx_byte = module_address[23:16];
                5'd4:    pkt.tx_byte = module_address[15:8];
                5'd5:    pkt.tx_byte = module_address[7:0];
                5'd6:    pkt.tx_byte = fcf_pkg::PID_COMMAND;
                5'd7:    pkt.tx_byte = 8'h00;
                5'd8:    pkt.tx_byte = len;
                default: pkt.tx_byte = instr;
            endcase
        end
        else if (off < {2'd0, np})
        begin
            pkt.tx_byte = par[off[2:0]];
        end
        else if (off == {2'd0, np})
        begin
            pkt.tx_byte = sum[15:8];
        end
        else
        begin
            pkt.tx_byte   = sum[7:0];
            pkt.last_byte = 1'b1;
        end
    end

endmodule

// ===== rtl/fingerprint_command_framer.sv =====
// ---------------------------------------------------------------------------
// fingerprint_command_framer
// Turns one command transaction into a fingerprint module command packet,
// one byte per output transaction, last byte flagged.
//   The command is registered first, then each byte in the output register.
//   A packet is 12 + parameter count bytes (12 to 17), one byte per cycle
//   while the output is not stalled by pkt_ready; the next command is taken
//   on the cycle the last byte leaves, so packets follow with no gap.
//   Unused opcodes are taken and produce no bytes.
//   Reset: asynchronous, active low; module address resets to FFFFFFFF.
// ---------------------------------------------------------------------------
module fingerprint_command_framer
(
    input  logic          clk,
    input  logic          rst_n,

    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,

    input  logic          cmd_valid,
    output logic          cmd_ready,
    input  fcf_pkg::cmd_t cmd,

    output logic          pkt_valid,
    input  logic          pkt_ready,
    output fcf_pkg::pkt_t pkt
);

    logic [31:0]   addr_reg;
    fcf_pkg::cmd_t cmd_reg;
    logic          busy_reg;
    logic          busy_next;
    logic [4:0]    idx_reg;
    logic [4:0]    idx_next;
    logic          pkt_valid_reg;
    logic          pkt_valid_next;
    fcf_pkg::pkt_t pkt_reg;
    fcf_pkg::pkt_t enc_pkt;

    logic out_free;
    logic emit;
    logic finish;
    logic accept;
    logic legal;
    logic cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == fcf_pkg::REG_MODULE_ADDRESS);
    assign prdata    = (paddr[2] == fcf_pkg::REG_MODULE_ADDRESS) ? addr_reg : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg <= fcf_pkg::MODULE_ADDRESS_RESET;
        end
        else if (cfg_write)
        begin
            addr_reg <= pwdata;
        end
    end

    fcf_encode u_encode
    (
        .cmd            (cmd_reg),
        .module_address (addr_reg),
        .idx            (idx_reg),
        .pkt            (enc_pkt)
    );

    assign out_free  = !pkt_valid_reg || pkt_ready;
    assign emit      = busy_reg && out_free;
    assign finish    = emit && enc_pkt.last_byte;
    assign cmd_ready = !busy_reg || finish;
    assign accept    = cmd_valid && cmd_ready;
    assign legal     = (cmd.opcode <= fcf_pkg::OP_MATCH);

    always_comb
    begin
        busy_next      = busy_reg;
        idx_next       = idx_reg;
        pkt_valid_next = pkt_valid_reg;
        if (accept)
        begin
            busy_next = legal;
            idx_next  = 5'd0;
        end
        else if (finish)
        begin
            busy_next = 1'b0;
        end
        else if (emit)
        begin
            idx_next = idx_reg + 5'd1;
        end
        if (emit)
        begin
            pkt_valid_next = 1'b1;
        end
        else if (pkt_ready)
        begin
            pkt_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= 5'd0;
            pkt_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            idx_reg       <= idx_next;
            pkt_valid_reg <= pkt_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd;
        end
        if (emit)
        begin
            pkt_reg <= enc_pkt;
        end
    end

    assign pkt_valid = pkt_valid_reg;
    assign pkt       = pkt_reg;

endmodule
